### rtl/core/ffa_pkg.sv
// shared types, codes and control store of the first-fit allocator
package ffa_pkg;

   // command codes carried by a request
   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_ERASE  = 2'd1;
   localparam logic [1:0] CMD_DEFRAG = 2'd2;

   typedef logic [2:0] status_type;

   // response status codes
   localparam status_type ST_ALLOCATED = 3'd0;
   localparam status_type ST_NO_SPACE  = 3'd1;
   localparam status_type ST_ILLEGAL   = 3'd2;
   localparam status_type ST_ERASED    = 3'd3;
   localparam status_type ST_DEFRAG    = 3'd4;

   // datapath operations driven by one control word
   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_SCAN_START,
      OP_ALLOC_SCAN,
      OP_ERASE_SCAN,
      OP_DEFRAG_SCAN,
      OP_FILL_HANDLE,
      OP_FILL_ZERO,
      OP_CLEAR_START,
      OP_RESP,
      OP_RESP_ALLOC,
      OP_RESP_ERASE
   } op_type;

   // branch conditions tested by the sequencer
   typedef enum logic [3:0] {
      C_NONE,
      C_ALWAYS,
      C_DISPATCH,
      C_ALLOC_BAD,
      C_RUN_HIT,
      C_NOT_LIM_END,
      C_NOT_MEM_END,
      C_FILL_MORE,
      C_HANDLE_ZERO,
      C_RESP_FREE
   } cond_type;

   typedef logic [4:0] step_type;

   // program step addresses
   localparam step_type S_IDLE      = 5'd0;
   localparam step_type S_A_CHK     = 5'd1;
   localparam step_type S_A_SCAN    = 5'd2;
   localparam step_type S_NOSPACE   = 5'd3;
   localparam step_type S_A_FILL    = 5'd4;
   localparam step_type S_A_DONE    = 5'd5;
   localparam step_type S_E_CHK     = 5'd6;
   localparam step_type S_E_SCAN    = 5'd7;
   localparam step_type S_E_DONE    = 5'd8;
   localparam step_type S_D_START   = 5'd9;
   localparam step_type S_D_SCAN    = 5'd10;
   localparam step_type S_D_FILL    = 5'd11;
   localparam step_type S_D_DONE    = 5'd12;
   localparam step_type S_ILL       = 5'd13;
   localparam step_type S_CLR_START = 5'd14;
   localparam step_type S_CLR       = 5'd15;
   localparam step_type S_CLR_DONE  = 5'd16;

   // one control word: jump on jmp_cond, else hold on wait_cond, else step on
   typedef struct packed {
      op_type     op;
      cond_type   jmp_cond;
      step_type   target;
      cond_type   wait_cond;
      status_type status;
   } uword_type;

   // sequencer to datapath
   typedef struct packed {
      op_type     op;
      status_type status;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic alloc_bad;
      logic run_hit;
      logic lim_end;
      logic mem_end;
      logic fill_more;
      logic handle_zero;
      logic resp_free;
   } flags_type;

   function automatic uword_type uw(op_type op, cond_type jc, step_type tgt,
                                    cond_type wc, status_type st);
      uword_type w;
      w.op        = op;
      w.jmp_cond  = jc;
      w.target    = tgt;
      w.wait_cond = wc;
      w.status    = st;
      return w;
   endfunction

   // control store
   function automatic uword_type ucode(step_type s);
      uword_type w;
      case (s)
         S_IDLE:      w = uw(OP_ACCEPT, C_DISPATCH, S_IDLE, C_ALWAYS, ST_ILLEGAL);
         S_A_CHK:     w = uw(OP_SCAN_START, C_ALLOC_BAD, S_NOSPACE, C_NONE, ST_NO_SPACE);
         S_A_SCAN:    w = uw(OP_ALLOC_SCAN, C_RUN_HIT, S_A_FILL, C_NOT_LIM_END,
                             ST_NO_SPACE);
         S_NOSPACE:   w = uw(OP_RESP, C_RESP_FREE, S_IDLE, C_ALWAYS, ST_NO_SPACE);
         S_A_FILL:    w = uw(OP_FILL_HANDLE, C_NONE, S_IDLE, C_FILL_MORE, ST_ALLOCATED);
         S_A_DONE:    w = uw(OP_RESP_ALLOC, C_RESP_FREE, S_IDLE, C_ALWAYS, ST_ALLOCATED);
         S_E_CHK:     w = uw(OP_SCAN_START, C_HANDLE_ZERO, S_E_DONE, C_NONE, ST_ILLEGAL);
         S_E_SCAN:    w = uw(OP_ERASE_SCAN, C_NONE, S_IDLE, C_NOT_MEM_END, ST_ERASED);
         S_E_DONE:    w = uw(OP_RESP_ERASE, C_RESP_FREE, S_IDLE, C_ALWAYS, ST_ERASED);
         S_D_START:   w = uw(OP_SCAN_START, C_NONE, S_IDLE, C_NONE, ST_DEFRAG);
         S_D_SCAN:    w = uw(OP_DEFRAG_SCAN, C_NONE, S_IDLE, C_NOT_MEM_END, ST_DEFRAG);
         S_D_FILL:    w = uw(OP_FILL_ZERO, C_NONE, S_IDLE, C_FILL_MORE, ST_DEFRAG);
         S_D_DONE:    w = uw(OP_RESP, C_RESP_FREE, S_IDLE, C_ALWAYS, ST_DEFRAG);
         S_ILL:       w = uw(OP_RESP, C_RESP_FREE, S_IDLE, C_ALWAYS, ST_ILLEGAL);
         S_CLR_START: w = uw(OP_CLEAR_START, C_NONE, S_IDLE, C_NONE, ST_ILLEGAL);
         S_CLR:       w = uw(OP_FILL_ZERO, C_NONE, S_IDLE, C_FILL_MORE, ST_ILLEGAL);
         S_CLR_DONE:  w = uw(OP_NOP, C_ALWAYS, S_IDLE, C_NONE, ST_ILLEGAL);
         default:     w = uw(OP_NOP, C_ALWAYS, S_IDLE, C_NONE, ST_ILLEGAL);
      endcase
      return w;
   endfunction

endpackage

### rtl/core/first_fit_memory_allocator.sv
// top level of the first-fit allocator with compaction
//
// Requests enter on the req_ stream: a command (allocate, erase, defragment)
// with an allocation size and an erase handle. Each request gives exactly one
// response on the rsp_ stream: a status and, for a granted allocation, the
// handle. Requests are handled one at a time by a microcoded sequencer that
// walks the owner map memory one word per cycle through its read port.
// An allocate scans the owner map up to the first fit and then fills the
// requested size; an erase scans the whole map; a defragment runs a
// compaction scan over the whole map, then clears the tail.
// A new request is taken in the cycle after a response is loaded, even while
// that response still waits on rsp_tready; the next response then waits in
// the sequencer until the output register is free.
// After reset the owner map is cleared in a pass during which req_tready
// stays low; CSR writes are accepted at any time.
// The memory_size register (byte address 0) limits where allocate may place
// blocks; it should be changed only while no request is in flight.
module first_fit_memory_allocator import ffa_pkg::*; #(
   parameter int MEM_WORDS = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // command[1:0], alloc_size[9:2], erase_handle[25:10]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status[2:0], handle[18:3]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic REG_MEMORY_SIZE = 1'b0;

   logic [7:0]  memory_size_ff, memory_size_in;
   ctrl_type    ctrl;
   flags_type   flags;
   status_type  rsp_status;
   logic [15:0] rsp_handle;
   logic        csr_write;

   // register write and read back
   always_comb begin
      csr_write      = csr_psel && csr_penable && csr_pwrite && csr_pready;
      memory_size_in = memory_size_ff;
      if (csr_write && (csr_paddr[2] == REG_MEMORY_SIZE)) begin
         memory_size_in = csr_pwdata[7:0];
      end
      csr_prdata = (csr_paddr[2] == REG_MEMORY_SIZE) ? {24'd0, memory_size_ff} : 32'd0;
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         memory_size_ff <= 8'd128;
      end else begin
         memory_size_ff <= memory_size_in;
      end
   end

   ffa_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_command (req_tdata[1:0]),
      .flags       (flags),
      .ctrl        (ctrl)
   );

   ffa_datapath #(
      .MEM_WORDS (MEM_WORDS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_valid        (req_tvalid),
      .req_alloc_size   (req_tdata[9:2]),
      .req_erase_handle (req_tdata[25:10]),
      .memory_size      (memory_size_ff),
      .rsp_ready        (rsp_tready),
      .flags            (flags),
      .rsp_valid        (rsp_tvalid),
      .rsp_status       (rsp_status),
      .rsp_handle       (rsp_handle)
   );

   // stream side
   assign req_tready = (ctrl.op == OP_ACCEPT);
   assign rsp_tdata  = {5'd0, rsp_handle, rsp_status};

endmodule

### rtl/core/ffa_ram.sv
// generic single-write, single-read memory with registered read data
module ffa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/core/ffa_sequencer.sv
// microcode sequencer: step counter, control store and branch logic
module ffa_sequencer import ffa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic [1:0] req_command,
   input  flags_type flags,
   output ctrl_type  ctrl
);

   step_type  step_ff;
   step_type  step_in;
   uword_type word;

   function automatic logic cond_met(cond_type c, flags_type f, logic rv);
      logic m;
      case (c)
         C_NONE:        m = 1'b0;
         C_ALWAYS:      m = 1'b1;
         C_DISPATCH:    m = rv;
         C_ALLOC_BAD:   m = f.alloc_bad;
         C_RUN_HIT:     m = f.run_hit;
         C_NOT_LIM_END: m = !f.lim_end;
         C_NOT_MEM_END: m = !f.mem_end;
         C_FILL_MORE:   m = f.fill_more;
         C_HANDLE_ZERO: m = f.handle_zero;
         C_RESP_FREE:   m = f.resp_free;
         default:       m = 1'b0;
      endcase
      return m;
   endfunction

   function automatic step_type dispatch(logic [1:0] cmd);
      step_type s;
      case (cmd)
         CMD_ALLOC:  s = S_A_CHK;
         CMD_ERASE:  s = S_E_CHK;
         CMD_DEFRAG: s = S_D_START;
         default:    s = S_ILL;
      endcase
      return s;
   endfunction

   // fetch and next-step selection
   always_comb begin
      word        = ucode(step_ff);
      ctrl.op     = word.op;
      ctrl.status = word.status;
      if (cond_met(word.jmp_cond, flags, req_valid)) begin
         step_in = (word.jmp_cond == C_DISPATCH) ? dispatch(req_command) : word.target;
      end else if (cond_met(word.wait_cond, flags, req_valid)) begin
         step_in = step_ff;
      end else begin
         step_in = step_ff + 5'd1;
      end
   end

   // step counter, starts with the owner map clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_CLR_START;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### rtl/core/ffa_datapath.sv
// owner map, scan counters, handle counter and response register
module ffa_datapath import ffa_pkg::*; #(
   parameter int MEM_WORDS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   input  logic        req_valid,
   input  logic [7:0]  req_alloc_size,
   input  logic [15:0] req_erase_handle,
   input  logic [7:0]  memory_size,
   input  logic        rsp_ready,
   output flags_type   flags,
   output logic        rsp_valid,
   output status_type  rsp_status,
   output logic [15:0] rsp_handle
);

   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int CW = $clog2(MEM_WORDS + 1);
   localparam logic [CW-1:0] MEM_END   = CW'(MEM_WORDS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

   logic [7:0]    size_ff, size_in;
   logic [15:0]   handle_ff, handle_in;
   logic [AW-1:0] chk_ff, chk_in;
   logic [7:0]    run_ff, run_in;
   logic          found_ff, found_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] end_ff, end_in;
   logic [15:0]   next_handle_ff, next_handle_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [15:0]   rsp_handle_ff, rsp_handle_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_data;

   logic [CW-1:0] lim;
   logic [CW-1:0] chk_next;
   logic [7:0]    run_new;
   logic          resp_free;

   ffa_ram #(
      .WIDTH (16),
      .DEPTH (MEM_WORDS)
   ) u_owner_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // usable words, scan position and run length
   always_comb begin
      if (32'(memory_size) > MEM_WORDS) begin
         lim = MEM_END;
      end else begin
         lim = CW'(memory_size);
      end
      chk_next  = CW'(chk_ff) + CW'(1);
      run_new   = (rd_data == 16'd0) ? run_ff + 8'd1 : 8'd0;
      resp_free = !rsp_valid_ff || rsp_ready;
   end

   // status flags for the sequencer
   always_comb begin
      flags.alloc_bad   = (size_ff == 8'd0) || (next_handle_ff == 16'd0) ||
                          (lim == '0);
      flags.run_hit     = (run_new == size_ff);
      flags.lim_end     = (chk_next == lim);
      flags.mem_end     = (chk_ff == LAST_ADDR);
      flags.fill_more   = (ptr_ff != end_ff) && ((ptr_ff + CW'(1)) != end_ff);
      flags.handle_zero = (handle_ff == 16'd0);
      flags.resp_free   = resp_free;
   end

   // operation decode
   always_comb begin
      size_in        = size_ff;
      handle_in      = handle_ff;
      chk_in         = chk_ff;
      run_in         = run_ff;
      found_in       = found_ff;
      ptr_in         = ptr_ff;
      end_in         = end_ff;
      next_handle_in = next_handle_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_handle_in  = rsp_handle_ff;
      wr_en          = 1'b0;
      wr_addr        = ptr_ff[AW-1:0];
      wr_data        = 16'd0;
      rd_addr        = '0;
      case (ctrl.op)
         OP_ACCEPT: begin
            if (req_valid) begin
               size_in   = req_alloc_size;
               handle_in = req_erase_handle;
            end
         end
         OP_SCAN_START: begin
            chk_in   = '0;
            run_in   = 8'd0;
            found_in = 1'b0;
            ptr_in   = '0;
            end_in   = MEM_END;
         end
         OP_ALLOC_SCAN: begin
            rd_addr = chk_next[AW-1:0];
            chk_in  = chk_next[AW-1:0];
            run_in  = run_new;
            if (run_new == size_ff) begin
               ptr_in = chk_next - CW'(size_ff);
               end_in = chk_next;
            end
         end
         OP_ERASE_SCAN: begin
            rd_addr = chk_next[AW-1:0];
            chk_in  = chk_next[AW-1:0];
            if (rd_data == handle_ff) begin
               wr_en    = 1'b1;
               wr_addr  = chk_ff;
               found_in = 1'b1;
            end
         end
         OP_DEFRAG_SCAN: begin
            rd_addr = chk_next[AW-1:0];
            chk_in  = chk_next[AW-1:0];
            if (rd_data != 16'd0) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               ptr_in  = ptr_ff + CW'(1);
            end
         end
         OP_FILL_HANDLE, OP_FILL_ZERO: begin
            if (ptr_ff != end_ff) begin
               wr_en   = 1'b1;
               wr_data = (ctrl.op == OP_FILL_HANDLE) ? next_handle_ff : 16'd0;
               ptr_in  = ptr_ff + CW'(1);
            end
         end
         OP_CLEAR_START: begin
            ptr_in = '0;
            end_in = MEM_END;
         end
         OP_RESP: begin
            if (resp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ctrl.status;
               rsp_handle_in = 16'd0;
            end
         end
         OP_RESP_ALLOC: begin
            if (resp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_ALLOCATED;
               rsp_handle_in  = next_handle_ff;
               next_handle_in = next_handle_ff + 16'd1;
            end
         end
         OP_RESP_ERASE: begin
            if (resp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_ff ? ST_ERASED : ST_ILLEGAL;
               rsp_handle_in = 16'd0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         next_handle_ff <= 16'd1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         next_handle_ff <= next_handle_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      handle_ff     <= handle_in;
      chk_ff        <= chk_in;
      run_ff        <= run_in;
      found_ff      <= found_in;
      ptr_ff        <= ptr_in;
      end_ff        <= end_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_handle = rsp_handle_ff;

endmodule
